### hdl/seam_linear_alpha_blend_unit_macros.svh
// Assertion macros for the seam blend unit.
// Used by the top level; no other dependencies.
`ifndef SEAM_LINEAR_ALPHA_BLEND_UNIT_MACROS_SVH
`define SEAM_LINEAR_ALPHA_BLEND_UNIT_MACROS_SVH

`define SLA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define SLA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/sla_pkg.sv
// Shared types and constants for the seam blend unit.
// No dependencies.
`default_nettype none

package sla_pkg;

   localparam int COLOR_W    = 8;
   localparam int NUM_LANES  = 3;
   localparam int DIV_STEPS  = COLOR_W;
   localparam int DIV_FIRST  = 3;
   localparam int PIPE_DEPTH = DIV_FIRST + DIV_STEPS;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH   = 1'b0,
      REG_SEAM_POSITION = 1'b1
   } sla_reg_type;

   typedef struct packed {
      logic in_band;
      logic mix;
   } sla_flags_type;

endpackage

`default_nettype wire

### hdl/sla_req_if.sv
// Input and result channel interfaces for the seam blend unit.
// Depends on sla_pkg.
`default_nettype none

interface sla_req_if #(parameter int COORD_BITS = 13);
   logic                         valid;
   logic                         ready;
   logic [COORD_BITS-1:0]        column;
   logic [sla_pkg::COLOR_W-1:0]  src_red;
   logic [sla_pkg::COLOR_W-1:0]  src_green;
   logic [sla_pkg::COLOR_W-1:0]  src_blue;
   logic [sla_pkg::COLOR_W-1:0]  dst_red;
   logic [sla_pkg::COLOR_W-1:0]  dst_green;
   logic [sla_pkg::COLOR_W-1:0]  dst_blue;

   modport source (
      output valid, column, src_red, src_green, src_blue, dst_red, dst_green, dst_blue,
      input  ready
   );
   modport sink (
      input  valid, column, src_red, src_green, src_blue, dst_red, dst_green, dst_blue,
      output ready
   );
endinterface

interface sla_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sla_pkg::COLOR_W-1:0]  out_red;
   logic [sla_pkg::COLOR_W-1:0]  out_green;
   logic [sla_pkg::COLOR_W-1:0]  out_blue;
   logic                         in_band;

   modport source (
      output valid, out_red, out_green, out_blue, in_band,
      input  ready
   );
   modport sink (
      input  valid, out_red, out_green, out_blue, in_band,
      output ready
   );
endinterface

`default_nettype wire

### hdl/sla_csr.sv
// Configuration registers and blend band width for the seam blend unit.
// Depends on sla_pkg.
`default_nettype none

module sla_csr #(
   parameter int COORD_BITS = 13,
   parameter int MAX_BAND   = 300
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [sla_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [sla_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [sla_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                           csr_pready,
   output      logic [COORD_BITS-1:0]          band
);

   localparam logic [COORD_BITS-1:0] WIDTH_RESET = COORD_BITS'(1920);

   logic [COORD_BITS-1:0] width_ff, width_in;
   logic [COORD_BITS-1:0] seam_ff, seam_in;
   logic [COORD_BITS-1:0] band_ff, band_in;
   logic [COORD_BITS-1:0] rest;
   sla_pkg::sla_reg_type  index;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign index      = sla_pkg::sla_reg_type'(csr_paddr[2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      width_in = width_ff;
      seam_in  = seam_ff;
      if (wr_en) begin
         unique case (index)
            sla_pkg::REG_IMAGE_WIDTH:   width_in = csr_pwdata[COORD_BITS-1:0];
            sla_pkg::REG_SEAM_POSITION: seam_in  = csr_pwdata[COORD_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (index)
         sla_pkg::REG_IMAGE_WIDTH:   csr_prdata = sla_pkg::CSR_DATA_W'(width_ff);
         sla_pkg::REG_SEAM_POSITION: csr_prdata = sla_pkg::CSR_DATA_W'(seam_ff);
      endcase
   end

   always_comb begin
      rest = width_ff - seam_ff;
      priority if (seam_ff < (width_ff >> 1)) begin
         band_in = seam_ff;
      end else if (seam_ff >= width_ff) begin
         band_in = '0;
      end else if (32'(rest) > MAX_BAND) begin
         band_in = COORD_BITS'(MAX_BAND);
      end else begin
         band_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         seam_ff  <= '0;
         band_ff  <= '0;
      end else begin
         width_ff <= width_in;
         seam_ff  <= seam_in;
         band_ff  <= band_in;
      end
   end

   assign band = band_ff;

endmodule

`default_nettype wire

### hdl/sla_lane.sv
// One color lane: weight products, sum, and a pipelined restoring divide by the band width.
// Depends on sla_pkg.
`default_nettype none

module sla_lane #(
   parameter int COORD_BITS = 13
) (
   input  wire logic                          clock,
   input  wire logic [sla_pkg::PIPE_DEPTH-1:0] load,
   input  wire logic [COORD_BITS-1:0]         band,
   input  wire logic [COORD_BITS-1:0]         column,
   input  wire logic [sla_pkg::COLOR_W-1:0]   src,
   input  wire logic [sla_pkg::COLOR_W-1:0]   dst,
   output      logic [sla_pkg::COLOR_W-1:0]   quot,
   output      logic [sla_pkg::COLOR_W-1:0]   dst_out
);

   localparam int CW     = sla_pkg::COLOR_W;
   localparam int STEPS  = sla_pkg::DIV_STEPS;
   localparam int DEPTH  = sla_pkg::PIPE_DEPTH;
   localparam int FIRST  = sla_pkg::DIV_FIRST;
   localparam int PROD_W = COORD_BITS + CW;
   localparam int NUM_W  = PROD_W + 1;

   logic [CW-1:0]     dst_ff [1:DEPTH-1];
   logic [PROD_W-1:0] src_prod_ff, src_prod_in;
   logic [PROD_W-1:0] dst_prod_ff, dst_prod_in;
   logic [NUM_W-1:0]  rem_ff [0:STEPS];
   logic [CW-1:0]     quo_ff [0:STEPS];
   logic [NUM_W-1:0]  num_in;

   assign src_prod_in = PROD_W'(src) * PROD_W'(band - column);
   assign dst_prod_in = PROD_W'(dst) * PROD_W'(column);
   assign num_in      = NUM_W'(src_prod_ff) + NUM_W'(dst_prod_ff);

   always_ff @(posedge clock) begin
      if (load[1]) begin
         src_prod_ff <= src_prod_in;
         dst_prod_ff <= dst_prod_in;
         dst_ff[1]   <= dst;
      end
      if (load[FIRST-1]) begin
         rem_ff[0] <= num_in;
         quo_ff[0] <= '0;
      end
   end

   for (genvar s = 2; s < DEPTH; s++) begin : g_dst
      always_ff @(posedge clock) begin
         if (load[s]) begin
            dst_ff[s] <= dst_ff[s-1];
         end
      end
   end

   for (genvar i = 1; i <= STEPS; i++) begin : g_div
      logic [NUM_W-1:0] dvs;
      logic             ge;
      logic [NUM_W-1:0] rem_in;
      logic [CW-1:0]    quo_in;

      assign dvs    = NUM_W'(band) << (STEPS - i);
      assign ge     = rem_ff[i-1] >= dvs;
      assign rem_in = ge ? (rem_ff[i-1] - dvs) : rem_ff[i-1];
      assign quo_in = {quo_ff[i-1][CW-2:0], ge};

      always_ff @(posedge clock) begin
         if (load[FIRST-1+i]) begin
            rem_ff[i] <= rem_in;
            quo_ff[i] <= quo_in;
         end
      end
   end

   assign quot    = quo_ff[STEPS];
   assign dst_out = dst_ff[DEPTH-1];

endmodule

`default_nettype wire

### hdl/seam_linear_alpha_blend_unit.sv
// Top level of the seam blend unit: input stage, three color lanes, merge and output register.
// Depends on sla_pkg, sla_req_if, sla_rsp_if, sla_csr, sla_lane and the macros header.
//
// channel   kind        fields
// req_chan  sink        column, src_red/green/blue, dst_red/green/blue
// rsp_chan  source      out_red/green/blue, in_band
// csr_*     APB slave   image_width at 0x0, seam_position at 0x4
//
// One transaction per cycle sustained while rsp_chan accepts results.
// Each lane uses an eight-step restoring divide, one quotient bit a stage.
// Reset clears the stage valid bits and loads image_width 1920, seam_position 0.
// Stages advance independently; a stalled rsp fills empty stages before req_chan.ready drops.
// The band width is registered in band_ff from the written width and seam registers.
`default_nettype none

`include "seam_linear_alpha_blend_unit_macros.svh"

module seam_linear_alpha_blend_unit #(
   parameter int MAX_BAND   = 300,
   parameter int COORD_BITS = 13
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   sla_req_if.sink                             req_chan,
   sla_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [sla_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [sla_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [sla_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                           csr_pready
);

   localparam int CW    = sla_pkg::COLOR_W;
   localparam int LANES = sla_pkg::NUM_LANES;
   localparam int DEPTH = sla_pkg::PIPE_DEPTH;

   logic [COORD_BITS-1:0]   band;
   logic [DEPTH:0]          load;
   logic [DEPTH-1:0]        v_ff, v_in;
   logic                    out_v_ff, out_v_in;
   sla_pkg::sla_flags_type  flags_ff [0:DEPTH-1];
   sla_pkg::sla_flags_type  flags_in;
   logic [COORD_BITS-1:0]   col_ff;
   logic [CW-1:0]           src_ff [0:LANES-1];
   logic [CW-1:0]           dst_ff [0:LANES-1];
   logic [CW-1:0]           src_bus [0:LANES-1];
   logic [CW-1:0]           dst_bus [0:LANES-1];
   logic [CW-1:0]           quot [0:LANES-1];
   logic [CW-1:0]           lane_dst [0:LANES-1];
   logic [CW-1:0]           out_ff [0:LANES-1];
   logic                    out_band_ff;
   logic                    out_mix_ff;
   logic                    src_nonzero;
   logic                    req_fire;
   logic                    pipe_full;
   logic                    rsp_mix;

   sla_csr #(
      .COORD_BITS (COORD_BITS),
      .MAX_BAND   (MAX_BAND)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .band        (band)
   );

   // advance a stage when it is empty or the next one advances
   always_comb begin
      load[DEPTH] = !out_v_ff || rsp_chan.ready;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         load[i] = !v_ff[i] || load[i+1];
      end
   end

   assign req_chan.ready = load[0];

   always_comb begin
      v_in = v_ff;
      if (load[0]) begin
         v_in[0] = req_chan.valid;
      end
      for (int i = 1; i < DEPTH; i++) begin
         if (load[i]) begin
            v_in[i] = v_ff[i-1];
         end
      end
      out_v_in = load[DEPTH] ? v_ff[DEPTH-1] : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else begin
         v_ff     <= v_in;
         out_v_ff <= out_v_in;
      end
   end

   assign src_bus[0] = req_chan.src_red;
   assign src_bus[1] = req_chan.src_green;
   assign src_bus[2] = req_chan.src_blue;
   assign dst_bus[0] = req_chan.dst_red;
   assign dst_bus[1] = req_chan.dst_green;
   assign dst_bus[2] = req_chan.dst_blue;

   assign src_nonzero      = (req_chan.src_red != '0) || (req_chan.src_green != '0)
                             || (req_chan.src_blue != '0);
   assign flags_in.in_band = (band != '0) && (req_chan.column < band);
   assign flags_in.mix     = flags_in.in_band && src_nonzero;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         col_ff      <= req_chan.column;
         flags_ff[0] <= flags_in;
         for (int c = 0; c < LANES; c++) begin
            src_ff[c] <= src_bus[c];
            dst_ff[c] <= dst_bus[c];
         end
      end
   end

   for (genvar s = 1; s < DEPTH; s++) begin : g_flags
      always_ff @(posedge clock) begin
         if (load[s]) begin
            flags_ff[s] <= flags_ff[s-1];
         end
      end
   end

   for (genvar c = 0; c < LANES; c++) begin : g_lane
      sla_lane #(
         .COORD_BITS (COORD_BITS)
      ) u_lane (
         .clock   (clock),
         .load    (load[DEPTH-1:0]),
         .band    (band),
         .column  (col_ff),
         .src     (src_ff[c]),
         .dst     (dst_ff[c]),
         .quot    (quot[c]),
         .dst_out (lane_dst[c])
      );
   end

   // merge lanes: blended value or destination passthrough
   always_ff @(posedge clock) begin
      if (load[DEPTH]) begin
         out_band_ff <= flags_ff[DEPTH-1].in_band;
         out_mix_ff  <= flags_ff[DEPTH-1].mix;
         for (int c = 0; c < LANES; c++) begin
            out_ff[c] <= flags_ff[DEPTH-1].mix ? quot[c] : lane_dst[c];
         end
      end
   end

   assign rsp_chan.valid     = out_v_ff;
   assign rsp_chan.out_red   = out_ff[0];
   assign rsp_chan.out_green = out_ff[1];
   assign rsp_chan.out_blue  = out_ff[2];
   assign rsp_chan.in_band   = out_band_ff;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign pipe_full = (&v_ff) && out_v_ff;
   assign rsp_mix   = out_v_ff && out_mix_ff;

   `SLA_ASSERT_NEXT(a_accept_fills_stage0, clock, reset, req_fire, v_ff[0], "lost transaction")
   `SLA_ASSERT_IMPLY(a_stall_only_full, clock, reset, !req_chan.ready, pipe_full, "early stall")
   `SLA_ASSERT_IMPLY(a_mix_only_in_band, clock, reset, rsp_mix, out_band_ff, "mix outside band")

endmodule

`default_nettype wire

### dv/seam_linear_alpha_blend_unit_tb.sv
// Testbench for seam_linear_alpha_blend_unit: feathered seam blend checked per pixel.
// Drives random pixel traffic and APB width and seam settings and scores results against a local predictor.
// Depends on sla_pkg, sla_req_if, sla_rsp_if and the unit under test.

module seam_linear_alpha_blend_unit_tb;

   localparam int COORD_BITS  = 13;
   localparam int MAX_BAND    = 300;
   localparam int COLOR_W     = sla_pkg::COLOR_W;
   localparam int CSR_ADDR_W  = sla_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W  = sla_pkg::CSR_DATA_W;
   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
   localparam int DRAIN       = sla_pkg::PIPE_DEPTH + 4;
   localparam int PHASE_ITEMS = 70;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [COORD_BITS-1:0] column;
      logic [COLOR_W-1:0]    src_red;
      logic [COLOR_W-1:0]    src_green;
      logic [COLOR_W-1:0]    src_blue;
      logic [COLOR_W-1:0]    dst_red;
      logic [COLOR_W-1:0]    dst_green;
      logic [COLOR_W-1:0]    dst_blue;
   } seam_pixel_type;

   typedef struct packed {
      logic [COLOR_W-1:0] out_red;
      logic [COLOR_W-1:0] out_green;
      logic [COLOR_W-1:0] out_blue;
      logic               in_band;
   } blended_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sla_req_if #(.COORD_BITS(COORD_BITS)) req_if ();
   sla_rsp_if                            rsp_if ();

   seam_linear_alpha_blend_unit #(
      .MAX_BAND  (MAX_BAND),
      .COORD_BITS(COORD_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_if),
      .rsp_chan   (rsp_if),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   int unsigned       image_width_q = 1920;
   int unsigned       seam_pos_q = 0;
   seam_pixel_type    pending_px[$];
   blended_pixel_type blended_due[$];
   seam_pixel_type    on_bus;
   int unsigned       req_gap = 0;
   bit                req_steady = 1'b0;
   int unsigned       rsp_hold = 0;
   bit                rsp_steady = 1'b0;
   int unsigned       mismatch_count = 0;
   int unsigned       results_seen = 0;
   int unsigned       cycle_count = 0;

   always #5 clock = ~clock;

   function automatic int unsigned seam_band(int unsigned width, int unsigned seam);
      if (seam < width / 2) return seam;
      if (seam >= width) return 0;
      return (width - seam > MAX_BAND) ? MAX_BAND : width - seam;
   endfunction

   function automatic logic [COLOR_W-1:0] feather(logic [COLOR_W-1:0] src,
                                                  logic [COLOR_W-1:0] dst,
                                                  int unsigned j, int unsigned w);
      int unsigned num;
      num = int'(src) * (w - j) + int'(dst) * j;
      return COLOR_W'(num / w);
   endfunction

   function automatic blended_pixel_type blend_pixel(seam_pixel_type px);
      blended_pixel_type res;
      int unsigned       w;
      w = seam_band(image_width_q, seam_pos_q);
      res.out_red   = px.dst_red;
      res.out_green = px.dst_green;
      res.out_blue  = px.dst_blue;
      res.in_band   = 1'b0;
      if (w != 0 && px.column < w) begin
         res.in_band = 1'b1;
         if (px.src_red != 0 || px.src_green != 0 || px.src_blue != 0) begin
            res.out_red   = feather(px.src_red, px.dst_red, px.column, w);
            res.out_green = feather(px.src_green, px.dst_green, px.column, w);
            res.out_blue  = feather(px.src_blue, px.dst_blue, px.column, w);
         end
      end
      return res;
   endfunction

   function automatic seam_pixel_type rand_pixel(int unsigned w);
      seam_pixel_type px;
      int unsigned    pick;
      int unsigned    col;
      pick = $urandom_range(0, 9);
      if (w == 0 || pick >= 8) col = $urandom_range(0, COORD_MAX);
      else if (pick == 7) col = w - 1 + $urandom_range(0, 2);
      else if (pick == 6) col = 0;
      else col = $urandom_range(0, w - 1);
      px.column = COORD_BITS'(col);
      pick = $urandom_range(0, 9);
      px.src_red   = COLOR_W'($urandom);
      px.src_green = COLOR_W'($urandom);
      px.src_blue  = COLOR_W'($urandom);
      px.dst_red   = COLOR_W'($urandom);
      px.dst_green = COLOR_W'($urandom);
      px.dst_blue  = COLOR_W'($urandom);
      if (pick == 0) begin
         px.src_red   = '0;
         px.src_green = '0;
         px.src_blue  = '0;
      end else if (pick == 1) begin
         px.src_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         px.src_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         px.src_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h01;
         px.dst_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         px.dst_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         px.dst_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      return px;
   endfunction

   task automatic queue_pixel(int unsigned col, logic [7:0] sr, logic [7:0] sg, logic [7:0] sb,
                              logic [7:0] dr, logic [7:0] dg, logic [7:0] db);
      seam_pixel_type px;
      px = '{COORD_BITS'(col), sr, sg, sb, dr, dg, db};
      pending_px = {pending_px, px};
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      if (mismatch_count < 50)
         $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
      mismatch_count++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_px.size() != 0 || req_if.valid || blended_due.size() != 0);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic write_csr(sla_pkg::sla_reg_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == sla_pkg::REG_IMAGE_WIDTH) image_width_q = value[COORD_BITS-1:0];
      else seam_pos_q = value[COORD_BITS-1:0];
   endtask

   task automatic apply_setting(int unsigned width, int unsigned seam);
      logic [CSR_DATA_W-1:0] junk;
      wait_idle();
      junk = $urandom_range(0, 1) ? $urandom : '0;
      write_csr(sla_pkg::REG_IMAGE_WIDTH,
                {junk[CSR_DATA_W-1:COORD_BITS], COORD_BITS'(width)});
      junk = $urandom_range(0, 1) ? $urandom : '0;
      write_csr(sla_pkg::REG_SEAM_POSITION,
                {junk[CSR_DATA_W-1:COORD_BITS], COORD_BITS'(seam)});
      repeat (3) @(negedge clock);
   endtask

   task automatic run_random(int unsigned count);
      int unsigned w;
      w = seam_band(image_width_q, seam_pos_q);
      repeat (count) pending_px = {pending_px, rand_pixel(w)};
   endtask

   always @(posedge clock) begin : req_driver
      bit fire;
      fire = req_if.valid && req_if.ready;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (fire) blended_due = {blended_due, blend_pixel(on_bus)};
         if (fire || !req_if.valid) begin
            if (req_gap > 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_px.size() > 0) begin
               on_bus = pending_px.pop_front();
               req_if.column    <= on_bus.column;
               req_if.src_red   <= on_bus.src_red;
               req_if.src_green <= on_bus.src_green;
               req_if.src_blue  <= on_bus.src_blue;
               req_if.dst_red   <= on_bus.dst_red;
               req_if.dst_green <= on_bus.dst_green;
               req_if.dst_blue  <= on_bus.dst_blue;
               req_if.valid     <= 1'b1;
               if ($urandom_range(0, 31) == 0) req_steady = !req_steady;
               req_gap = req_steady ? 0 : $urandom_range(0, 16);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      blended_pixel_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (blended_due.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               want = blended_due.pop_front();
               if (rsp_if.out_red !== want.out_red)
                  report_mismatch("out_red", rsp_if.out_red, want.out_red);
               if (rsp_if.out_green !== want.out_green)
                  report_mismatch("out_green", rsp_if.out_green, want.out_green);
               if (rsp_if.out_blue !== want.out_blue)
                  report_mismatch("out_blue", rsp_if.out_blue, want.out_blue);
               if (rsp_if.in_band !== want.in_band)
                  report_mismatch("in_band", rsp_if.in_band, want.in_band);
            end
            results_seen++;
            if ($urandom_range(0, 31) == 0) rsp_steady = !rsp_steady;
            rsp_hold = rsp_steady ? 0 : $urandom_range(0, 16);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_if.ready <= (rsp_hold == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int unsigned fixed_width[13] = '{1920, 1920, 1920, 8191, 8191, 8191, 1, 0, 2, 3, 100,
                                       8191, 1000};
      int unsigned fixed_seam[13]  = '{1700, 1000, 959, 4095, 4094, 8191, 0, 0, 1, 1, 60,
                                       0, 1200};
      int unsigned width;
      int unsigned seam;
      req_if.valid     = 1'b0;
      req_if.column    = '0;
      req_if.src_red   = '0;
      req_if.src_green = '0;
      req_if.src_blue  = '0;
      req_if.dst_red   = '0;
      req_if.dst_green = '0;
      req_if.dst_blue  = '0;
      rsp_if.ready     = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings give an empty band
      queue_pixel(0, 255, 255, 255, 0, 0, 0);
      queue_pixel(100, 12, 34, 56, 78, 90, 123);
      queue_pixel(COORD_MAX, 255, 0, 255, 1, 254, 7);

      apply_setting(1920, 500);
      queue_pixel(0, 255, 255, 255, 0, 0, 0);
      queue_pixel(0, 0, 0, 0, 17, 200, 99);
      queue_pixel(0, 1, 2, 3, 255, 255, 255);
      queue_pixel(1, 255, 255, 255, 255, 255, 255);
      queue_pixel(250, 255, 0, 128, 0, 255, 64);
      queue_pixel(250, 0, 0, 0, 10, 20, 30);
      queue_pixel(250, 0, 0, 1, 255, 255, 255);
      queue_pixel(499, 255, 255, 255, 0, 0, 0);
      queue_pixel(499, 1, 1, 1, 255, 255, 255);
      queue_pixel(499, 0, 0, 0, 255, 0, 255);
      queue_pixel(500, 255, 255, 255, 0, 0, 0);
      queue_pixel(501, 9, 8, 7, 6, 5, 4);
      queue_pixel(4096, 255, 255, 255, 0, 0, 0);
      queue_pixel(COORD_MAX, 200, 100, 50, 25, 12, 6);
      queue_pixel(2730, 170, 85, 170, 85, 170, 85);
      queue_pixel(5461, 85, 170, 85, 170, 85, 170);

      foreach (fixed_width[k]) begin
         apply_setting(fixed_width[k], fixed_seam[k]);
         run_random(PHASE_ITEMS);
      end
      repeat (7) begin
         width = $urandom_range(1, COORD_MAX);
         if ($urandom_range(0, 1)) seam = $urandom_range(0, width / 2);
         else seam = $urandom_range(width / 2, COORD_MAX);
         apply_setting(width, seam);
         run_random(PHASE_ITEMS);
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
